FILE: hdl/assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

FILE: hdl/bse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

   // element store geometry
   localparam int MAX_ELEMS = 16;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FIRST,
      ST_STEP,
      ST_END,
      ST_OUT
   } state_type;

   // store port controls driven by the sequencer
   typedef struct packed {
      logic     we;
      addr_type waddr;
      data_type wdata;
      logic     re;
      addr_type raddr;
   } ram_ctrl_type;

   // compare unit result
   typedef struct packed {
      data_type lo;
      data_type hi;
   } minmax_type;

endpackage

`default_nettype wire

FILE: hdl/bse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/bse_minmax.sv
`timescale 1ns / 1ps
`default_nettype none

module bse_minmax (
   input  wire bse_pkg::data_type   a,
   input  wire bse_pkg::data_type   b,
   output bse_pkg::minmax_type      res
);

   logic swap;

   // equal values stay in place
   assign swap   = (a > b);
   assign res.lo = swap ? b : a;
   assign res.hi = swap ? a : b;

endmodule

`default_nettype wire

FILE: hdl/bubble_sort_engine.sv
// a batch of n elements loads one per beat; for n >= 2 the sort then runs in bubble
// passes, then n result beats follow back to back (a lone element goes straight out)
// no new batch is taken while busy; every compare-swap goes through the shared
// min/max unit; busy drops as the final result beat appears
// reset: synchronous, active high; clears state, count, overflow flag, strobe
// results are strobed for one cycle each and cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bubble_sort_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [31:0]       req_value,
   input  wire logic                     req_last,
   output logic                          rsp_strobe,
   output logic signed [31:0]            rsp_sorted_value,
   output logic                          rsp_last_out,
   output logic                          rsp_overflow
);

   bse_pkg::state_type    state_ff, state_in;
   bse_pkg::count_type    count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   bse_pkg::addr_type     idx_ff, idx_in;
   bse_pkg::addr_type     pass_ff, pass_in;
   bse_pkg::data_type     held_ff, held_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   bse_pkg::ram_ctrl_type ram_ctrl;
   logic [bse_pkg::DATA_W-1:0] ram_rdata;
   bse_pkg::data_type     rd_value;
   bse_pkg::minmax_type   mm;

   logic                  accept;
   logic                  room;
   bse_pkg::count_type    cnt_next;
   bse_pkg::addr_type     last_idx;
   logic                  idx_at_last;
   logic                  pass_done;

   // handshake and shared terms
   assign busy        = (state_ff != bse_pkg::ST_IDLE);
   assign accept      = start && !busy;
   assign room        = (count_ff < bse_pkg::count_type'(bse_pkg::MAX_ELEMS));
   assign cnt_next    = room ? bse_pkg::count_type'(count_ff + 1'b1) : count_ff;
   assign last_idx    = bse_pkg::addr_type'(count_ff - bse_pkg::count_type'(1));
   assign idx_at_last = (idx_ff == last_idx);
   assign pass_done   = (pass_ff == bse_pkg::addr_type'(count_ff - bse_pkg::count_type'(2)));
   assign rd_value    = $signed(ram_rdata);

   // element store
   bse_ram #(
      .WIDTH(bse_pkg::DATA_W),
      .DEPTH(bse_pkg::MAX_ELEMS)
   ) u_store (
      .clock (clock),
      .we    (ram_ctrl.we),
      .waddr (ram_ctrl.waddr),
      .wdata (ram_ctrl.wdata),
      .re    (ram_ctrl.re),
      .raddr (ram_ctrl.raddr),
      .rdata (ram_rdata)
   );

   // shared compare-swap unit: held element against the one just read
   bse_minmax u_minmax (
      .a   (held_ff),
      .b   (rd_value),
      .res (mm)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bse_pkg::ST_IDLE: begin
            if (accept && req_last) begin
               state_in = (cnt_next >= bse_pkg::count_type'(2)) ? bse_pkg::ST_LOAD
                                                                 : bse_pkg::ST_OUT;
            end
         end
         bse_pkg::ST_LOAD:  state_in = bse_pkg::ST_FIRST;
         bse_pkg::ST_FIRST: state_in = bse_pkg::ST_STEP;
         bse_pkg::ST_STEP: begin
            if (idx_at_last) begin
               state_in = bse_pkg::ST_END;
            end
         end
         bse_pkg::ST_END: begin
            state_in = pass_done ? bse_pkg::ST_OUT : bse_pkg::ST_FIRST;
         end
         bse_pkg::ST_OUT: begin
            if (idx_at_last) begin
               state_in = bse_pkg::ST_IDLE;
            end
         end
         default: state_in = bse_pkg::ST_IDLE;
      endcase
   end

   // store port and result strobe
   always_comb begin
      ram_ctrl        = '0;
      rsp_strobe_in   = 1'b0;
      rsp_last_in     = 1'b0;
      rsp_overflow_in = 1'b0;
      case (state_ff)
         bse_pkg::ST_IDLE: begin
            ram_ctrl.we    = accept && room;
            ram_ctrl.waddr = count_ff[bse_pkg::ADDR_W-1:0];
            ram_ctrl.wdata = req_value;
         end
         bse_pkg::ST_LOAD: begin
            ram_ctrl.re    = 1'b1;
            ram_ctrl.raddr = '0;
         end
         bse_pkg::ST_FIRST: begin
            ram_ctrl.re    = 1'b1;
            ram_ctrl.raddr = bse_pkg::addr_type'(1);
         end
         bse_pkg::ST_STEP: begin
            // smaller one settles one slot back, read ahead for the next step
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = bse_pkg::addr_type'(idx_ff - 1'b1);
            ram_ctrl.wdata = mm.lo;
            ram_ctrl.re    = !idx_at_last;
            ram_ctrl.raddr = bse_pkg::addr_type'(idx_ff + 1'b1);
         end
         bse_pkg::ST_END: begin
            // largest of the pass lands at the top, restart from the bottom
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = last_idx;
            ram_ctrl.wdata = held_ff;
            ram_ctrl.re    = !pass_done;
            ram_ctrl.raddr = '0;
         end
         bse_pkg::ST_OUT: begin
            ram_ctrl.re     = 1'b1;
            ram_ctrl.raddr  = idx_ff;
            rsp_strobe_in   = 1'b1;
            rsp_last_in     = idx_at_last;
            rsp_overflow_in = dropped_ff;
         end
         default: begin
            ram_ctrl = '0;
         end
      endcase
   end

   // counters and held element
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      held_in    = held_ff;
      case (state_ff)
         bse_pkg::ST_IDLE: begin
            idx_in  = '0;
            pass_in = '0;
            if (accept) begin
               count_in   = cnt_next;
               dropped_in = dropped_ff || !room;
            end
         end
         bse_pkg::ST_LOAD: begin
            idx_in = '0;
         end
         bse_pkg::ST_FIRST: begin
            held_in = rd_value;
            idx_in  = bse_pkg::addr_type'(1);
         end
         bse_pkg::ST_STEP: begin
            held_in = mm.hi;
            idx_in  = bse_pkg::addr_type'(idx_ff + 1'b1);
         end
         bse_pkg::ST_END: begin
            pass_in = bse_pkg::addr_type'(pass_ff + 1'b1);
            idx_in  = '0;
         end
         bse_pkg::ST_OUT: begin
            idx_in = bse_pkg::addr_type'(idx_ff + 1'b1);
            if (idx_at_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bse_pkg::ST_IDLE;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff          <= idx_in;
      pass_ff         <= pass_in;
      held_ff         <= held_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // result beat
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = rd_value;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   // checks
   `ASSERT_NEVER(a_no_rw_same_addr, clock, reset, ram_ctrl.we && ram_ctrl.re && (ram_ctrl.waddr == ram_ctrl.raddr), "store read and write hit the same entry")
   `ASSERT_AT(a_last_ends_run, clock, reset, rsp_strobe_ff && rsp_last_ff |=> !rsp_strobe_ff, "result beat after the final one")
   `ASSERT_NEVER(a_out_nonempty, clock, reset, (state_ff == bse_pkg::ST_OUT) && (count_ff == '0), "emitting an empty batch")

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   // one sorted element as it leaves the block
   typedef struct packed {
      bse_pkg::data_type sorted_value;
      logic              last_out;
      logic              overflow;
   } sorted_beat_type;

   // one row of the directed table; known is used only when has_known is set
   typedef struct packed {
      bse_pkg::data_type value;
      logic              last;
      logic              has_known;
      sorted_beat_type   known;
   } stim_row_type;

   localparam bse_pkg::data_type VAL_MIN = 32'sh8000_0000;
   localparam bse_pkg::data_type VAL_MAX = 32'sh7fff_ffff;
   localparam int       RANDOM_ITEMS = 235;
   localparam int       QUIET_TAIL   = 40;
   localparam int       STALL_LIMIT  = 2000;
   localparam int       SETTLE       = 300;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   bse_pkg::data_type req_value;
   logic              req_last;
   logic              rsp_strobe;
   bse_pkg::data_type rsp_sorted_value;
   logic              rsp_last_out;
   logic              rsp_overflow;

   // known answer travelling with the beat on the request side
   logic            row_has_known;
   sorted_beat_type row_known;

   // batch being collected by the predictor
   bse_pkg::data_type held_elems [bse_pkg::MAX_ELEMS];
   int              held_count;
   logic            held_overflow;
   sorted_beat_type sorted_run [$];

   sorted_beat_type expected_beats [$];
   stim_row_type    directed_rows [$];
   int              fail_count;
   int              stall_cycles;
   logic            beat_seen;

   bubble_sort_engine uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predictor: store the element, and on a last mark sort the batch and emit it
   task automatic take_element(input bse_pkg::data_type v, input logic is_last);
      bse_pkg::data_type swap_tmp;
      int       pass_i;
      int       k;
      sorted_run.delete();
      if (held_count < bse_pkg::MAX_ELEMS) begin
         held_elems[held_count] = v;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (is_last) begin
         for (pass_i = 0; pass_i + 1 < held_count; pass_i++) begin
            for (k = 0; k + 1 < held_count; k++) begin
               if (held_elems[k] > held_elems[k+1]) begin
                  swap_tmp        = held_elems[k];
                  held_elems[k]   = held_elems[k+1];
                  held_elems[k+1] = swap_tmp;
               end
            end
         end
         for (k = 0; k < held_count; k++)
            sorted_run.push_back(sorted_beat_type'{held_elems[k], k + 1 == held_count,
                                                   held_overflow});
         held_count    = 0;
         held_overflow = 1'b0;
      end
   endtask

   // compare one result beat against the oldest expectation
   task automatic check_result();
      sorted_beat_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected result: sorted_value %0d", rsp_sorted_value);
         fail_count++;
      end else begin
         want = expected_beats.pop_front();
         if (rsp_sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   rsp_sorted_value);
            fail_count++;
         end
         if (rsp_last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, rsp_last_out);
            fail_count++;
         end
         if (rsp_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
            fail_count++;
         end
      end
   endtask

   // monitor: results, accepted beats and the watchdog, all at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         beat_seen = 1'b0;
         if (rsp_strobe) begin
            beat_seen = 1'b1;
            check_result();
         end
         if (start && !busy) begin
            beat_seen = 1'b1;
            take_element(req_value, req_last);
            if (row_has_known && req_last)
               expected_beats.push_back(row_known);
            else
               foreach (sorted_run[i]) expected_beats.push_back(sorted_run[i]);
         end
         if (beat_seen) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   // present one beat at the falling edge and hold it until accepted
   task automatic send_beat(input bse_pkg::data_type v, input logic is_last,
                            input logic has_known, input sorted_beat_type known);
      @(negedge clock);
      start         <= 1'b1;
      req_value     <= v;
      req_last      <= is_last;
      row_has_known <= has_known;
      row_known     <= known;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every expected result has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   // extremes, near-duplicates and fully random patterns
   function automatic bse_pkg::data_type random_element();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3:    return bse_pkg::data_type'(int'($urandom_range(0, 8)) - 4);
         default: return bse_pkg::data_type'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      int   i;
      int   k;
      int   items_sent;
      int   batch_len;
      logic idle_on;
      logic paused;

      reset         = 1'b1;
      start         = 1'b0;
      req_value     = '0;
      req_last      = 1'b0;
      row_has_known = 1'b0;
      row_known     = '0;
      held_count    = 0;
      held_overflow = 1'b0;
      fail_count    = 0;
      stall_cycles  = 0;
      items_sent    = 0;
      paused        = 1'b0;

      // directed table: single-element batches of the extremes, zero and -1 have known answers
      directed_rows.push_back(stim_row_type'{VAL_MIN, 1'b1, 1'b1, {VAL_MIN, 1'b1, 1'b0}});
      directed_rows.push_back(stim_row_type'{VAL_MAX, 1'b1, 1'b1, {VAL_MAX, 1'b1, 1'b0}});
      directed_rows.push_back(stim_row_type'{32'sd0, 1'b1, 1'b1, {32'sd0, 1'b1, 1'b0}});
      directed_rows.push_back(stim_row_type'{-32'sd1, 1'b1, 1'b1, {-32'sd1, 1'b1, 1'b0}});
      // reversed pair across the sign boundary
      directed_rows.push_back(stim_row_type'{VAL_MAX, 1'b0, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{VAL_MIN, 1'b1, 1'b0, '0});
      // equal elements
      directed_rows.push_back(stim_row_type'{32'sd9, 1'b0, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{32'sd9, 1'b1, 1'b0, '0});
      // full store, then a last mark that is dropped but still starts the sort
      for (k = 0; k <= bse_pkg::MAX_ELEMS; k++)
         directed_rows.push_back(stim_row_type'{
            bse_pkg::data_type'((k * 32'h1357_9bdf) ^ 32'ha5a5_0000),
            k == bse_pkg::MAX_ELEMS, 1'b0, '0});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 19));
         send_beat(directed_rows[r].value, directed_rows[r].last,
                   directed_rows[r].has_known, directed_rows[r].known);
      end
      drain();

      // random batches, mostly within capacity, some overflowing
      while (items_sent < RANDOM_ITEMS) begin
         batch_len = ($urandom_range(0, 7) == 0)
                        ? $urandom_range(bse_pkg::MAX_ELEMS + 1, bse_pkg::MAX_ELEMS + 4)
                        : $urandom_range(1, bse_pkg::MAX_ELEMS);
         idle_on   = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
         for (i = 0; i < batch_len; i++) begin
            if (idle_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 19));
            send_beat(random_element(), i == batch_len - 1, 1'b0, '0);
            items_sent++;
         end
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
      end

      // wait out the last batch, then a little longer for stray beats
      drain();
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
